// File: sv/pgtr_pkg.sv
// Package: shared types, constants and the 3x5 font table of the glyph renderer.
`timescale 1ns / 1ps
`default_nettype none

package pgtr_pkg;

    localparam int CODE_W     = 7;
    localparam int COORD_W    = 8;
    localparam int SW_W       = 4;
    localparam int GLYPH_W    = 15;
    localparam int ROW_W      = 3;
    localparam int ROM_DEPTH  = 93;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CODE_W-1:0]  ASCII_SPACE       = 7'd32;
    localparam logic [CODE_W-1:0]  ROM_FIRST         = 7'd33;
    localparam logic [CODE_W-1:0]  ROM_LAST          = 7'd125;
    localparam logic [ROW_W-1:0]   ROW_LAST          = 3'd4;
    localparam logic [SW_W-1:0]    SPACE_COLS_RESET  = 4'd2;

    // Register index, taken from paddr above the byte offset
    typedef enum logic [0:0] {
        REG_SPACE_COLS = 1'b0
    } pgtr_reg_t;

    // Per-character job handed from the front end to the bit scanner
    typedef struct packed {
        logic [GLYPH_W-1:0] bits;
        logic               empty;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] next_x;
        logic [COORD_W-1:0] str_width;
    } pgtr_job_t;

    // Entry = {col3, col2, col1}, 5 bits per column, bit 0 is the top row
    localparam logic [GLYPH_W-1:0] GLYPH_ROM [ROM_DEPTH] = '{
        {5'h00, 5'h00, 5'h17}, {5'h03, 5'h00, 5'h03}, {5'h0e, 5'h0e, 5'h0e},
        {5'h00, 5'h00, 5'h00}, {5'h13, 5'h04, 5'h19}, {5'h00, 5'h00, 5'h00},
        {5'h00, 5'h00, 5'h03}, {5'h00, 5'h11, 5'h0e}, {5'h00, 5'h0e, 5'h11},
        {5'h00, 5'h00, 5'h00}, {5'h04, 5'h0e, 5'h04}, {5'h00, 5'h08, 5'h10},
        {5'h00, 5'h04, 5'h04}, {5'h00, 5'h00, 5'h10}, {5'h03, 5'h04, 5'h18},
        {5'h0e, 5'h11, 5'h0e}, {5'h10, 5'h1f, 5'h12}, {5'h12, 5'h15, 5'h19},
        {5'h0a, 5'h15, 5'h11}, {5'h1f, 5'h04, 5'h07}, {5'h09, 5'h15, 5'h17},
        {5'h08, 5'h15, 5'h0e}, {5'h07, 5'h19, 5'h01}, {5'h0a, 5'h15, 5'h0a},
        {5'h0e, 5'h15, 5'h02}, {5'h00, 5'h00, 5'h0a}, {5'h00, 5'h0a, 5'h10},
        {5'h0a, 5'h04, 5'h04}, {5'h0a, 5'h0a, 5'h0a}, {5'h04, 5'h04, 5'h0a},
        {5'h02, 5'h15, 5'h01}, {5'h00, 5'h00, 5'h00}, {5'h1e, 5'h05, 5'h1e},
        {5'h0a, 5'h15, 5'h1f}, {5'h11, 5'h11, 5'h0e}, {5'h0e, 5'h11, 5'h1f},
        {5'h11, 5'h15, 5'h1f}, {5'h01, 5'h05, 5'h1f}, {5'h19, 5'h11, 5'h0e},
        {5'h1f, 5'h04, 5'h1f}, {5'h11, 5'h1f, 5'h11}, {5'h00, 5'h0f, 5'h11},
        {5'h1b, 5'h04, 5'h1f}, {5'h10, 5'h10, 5'h1f}, {5'h1f, 5'h02, 5'h1f},
        {5'h1e, 5'h01, 5'h1f}, {5'h1f, 5'h11, 5'h1f}, {5'h02, 5'h05, 5'h1f},
        {5'h1e, 5'h11, 5'h0e}, {5'h1a, 5'h05, 5'h1f}, {5'h09, 5'h15, 5'h12},
        {5'h01, 5'h1f, 5'h01}, {5'h1f, 5'h10, 5'h1f}, {5'h07, 5'h18, 5'h07},
        {5'h1f, 5'h08, 5'h1f}, {5'h1b, 5'h04, 5'h1b}, {5'h0f, 5'h14, 5'h03},
        {5'h13, 5'h15, 5'h19}, {5'h00, 5'h11, 5'h1f}, {5'h18, 5'h04, 5'h03},
        {5'h00, 5'h1f, 5'h11}, {5'h02, 5'h01, 5'h02}, {5'h10, 5'h10, 5'h10},
        {5'h00, 5'h02, 5'h01}, {5'h1e, 5'h12, 5'h0c}, {5'h0c, 5'h12, 5'h1f},
        {5'h12, 5'h12, 5'h0c}, {5'h1f, 5'h12, 5'h0c}, {5'h14, 5'h1a, 5'h0c},
        {5'h00, 5'h05, 5'h1e}, {5'h00, 5'h1e, 5'h16}, {5'h1c, 5'h02, 5'h1f},
        {5'h00, 5'h00, 5'h1d}, {5'h00, 5'h0d, 5'h10}, {5'h1a, 5'h04, 5'h1f},
        {5'h00, 5'h00, 5'h1f}, {5'h1e, 5'h04, 5'h1e}, {5'h1c, 5'h02, 5'h1e},
        {5'h0c, 5'h12, 5'h0c}, {5'h04, 5'h0a, 5'h1e}, {5'h1e, 5'h0a, 5'h04},
        {5'h02, 5'h04, 5'h1e}, {5'h00, 5'h1a, 5'h16}, {5'h00, 5'h12, 5'h0f},
        {5'h1e, 5'h10, 5'h0e}, {5'h06, 5'h18, 5'h06}, {5'h1e, 5'h08, 5'h1e},
        {5'h12, 5'h0c, 5'h12}, {5'h0e, 5'h14, 5'h02}, {5'h00, 5'h16, 5'h1a},
        {5'h1f, 5'h0e, 5'h04}, {5'h00, 5'h00, 5'h00}, {5'h04, 5'h0e, 5'h1f}
    };

    // Codes outside the table read as a blank glyph
    function automatic logic [GLYPH_W-1:0] glyph_bits(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] idx;
        idx = code - ROM_FIRST;
        if (code >= ROM_FIRST && code <= ROM_LAST)
            return GLYPH_ROM[idx];
        return '0;
    endfunction

endpackage

`default_nettype wire

// File: sv/pgtr_if.sv
// Interfaces: character input channel and pixel result channel.
`timescale 1ns / 1ps
`default_nettype none

interface pgtr_char_if;
    logic                         valid;
    logic                         ready;
    logic [pgtr_pkg::CODE_W-1:0]  code;
    logic                         first_char;
    logic                         string_end;
    logic [pgtr_pkg::COORD_W-1:0] pos_x;
    logic [pgtr_pkg::COORD_W-1:0] pos_y;

    modport source (output valid, code, first_char, string_end, pos_x, pos_y, input ready);
    modport sink (input valid, code, first_char, string_end, pos_x, pos_y, output ready);
endinterface

interface pgtr_pix_if;
    logic                         valid;
    logic                         ready;
    logic [pgtr_pkg::COORD_W-1:0] pixel_x;
    logic [pgtr_pkg::COORD_W-1:0] pixel_y;
    logic                         pixel_valid;
    logic                         end_of_run;
    logic [pgtr_pkg::COORD_W-1:0] next_x;
    logic [pgtr_pkg::COORD_W-1:0] str_width;

    modport source (output valid, pixel_x, pixel_y, pixel_valid, end_of_run, next_x,
                    str_width, input ready);
    modport sink (input valid, pixel_x, pixel_y, pixel_valid, end_of_run, next_x,
                  str_width, output ready);
endinterface

`default_nettype wire

// File: sv/pgtr_apb.sv
// APB register slave holding the space width setting.
`timescale 1ns / 1ps
`default_nettype none

module pgtr_apb (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [pgtr_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [pgtr_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [pgtr_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    output logic      [pgtr_pkg::SW_W-1:0]       space_cols
);
    import pgtr_pkg::*;

    logic [SW_W-1:0] space_cols_reg;
    logic [SW_W-1:0] space_cols_next;
    logic            wr_en;
    pgtr_reg_t       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = pgtr_reg_t'(paddr[APB_ADDR_W-1]);

    always_comb
    begin
        space_cols_next = space_cols_reg;
        prdata          = '0;
        unique case (reg_sel)
            REG_SPACE_COLS:
            begin
                prdata = {{(APB_DATA_W-SW_W){1'b0}}, space_cols_reg};
                if (wr_en)
                    space_cols_next = pwdata[SW_W-1:0];
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            space_cols_reg <= SPACE_COLS_RESET;
        else
            space_cols_reg <= space_cols_next;
    end

    assign space_cols = space_cols_reg;

endmodule

`default_nettype wire

// File: sv/pgtr_scan.sv
// Glyph scanner: one bit a cycle into the result register, stalled while it is full.
`timescale 1ns / 1ps
`default_nettype none

module pgtr_scan (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire pgtr_pkg::pgtr_job_t job,
    output logic                     busy,
    pgtr_pix_if.source               pix_ch
);
    import pgtr_pkg::*;

    logic               busy_reg, busy_next;
    logic [GLYPH_W-1:0] bits_reg, bits_next;
    logic               empty_reg, empty_next;
    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] row_base_reg, row_base_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COORD_W-1:0] nx_reg, nx_next;
    logic [COORD_W-1:0] tw_reg, tw_next;

    logic               ov_reg, ov_next;
    logic [COORD_W-1:0] ox_reg, ox_next;
    logic [COORD_W-1:0] oy_reg, oy_next;
    logic               opv_reg, opv_next;
    logic               oend_reg, oend_next;
    logic [COORD_W-1:0] onx_reg, onx_next;
    logic [COORD_W-1:0] otw_reg, otw_next;

    logic step;
    logic emit;
    logic last;

    // One bit per step; a step waits while a result is still held
    assign step = busy_reg && (!ov_reg || pix_ch.ready);
    assign last = empty_reg || (bits_reg[GLYPH_W-1:1] == '0);
    assign emit = step && (bits_reg[0] || empty_reg);

    always_comb
    begin
        busy_next     = busy_reg;
        bits_next     = bits_reg;
        empty_next    = empty_reg;
        col_next      = col_reg;
        row_base_next = row_base_reg;
        row_next      = row_reg;
        nx_next       = nx_reg;
        tw_next       = tw_reg;
        ov_next       = ov_reg && !pix_ch.ready;
        ox_next       = ox_reg;
        oy_next       = oy_reg;
        opv_next      = opv_reg;
        oend_next     = oend_reg;
        onx_next      = onx_reg;
        otw_next      = otw_reg;

        if (load)
        begin
            busy_next     = 1'b1;
            bits_next     = job.bits;
            empty_next    = job.empty;
            col_next      = job.col;
            row_base_next = job.row;
            row_next      = '0;
            nx_next       = job.next_x;
            tw_next       = job.str_width;
        end
        else if (step)
        begin
            if (last)
                busy_next = 1'b0;
            bits_next = bits_reg >> 1;
            if (row_reg == ROW_LAST)
            begin
                row_next = '0;
                col_next = col_reg + 1'b1;
            end
            else
            begin
                row_next = row_reg + 1'b1;
            end
        end

        if (emit)
        begin
            ov_next   = 1'b1;
            opv_next  = !empty_reg;
            oend_next = last;
            onx_next  = nx_reg;
            otw_next  = tw_reg;
            if (empty_reg)
            begin
                ox_next = '0;
                oy_next = '0;
            end
            else
            begin
                ox_next = col_reg;
                oy_next = row_base_reg + {{(COORD_W-ROW_W){1'b0}}, row_reg};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg     <= bits_next;
        empty_reg    <= empty_next;
        col_reg      <= col_next;
        row_base_reg <= row_base_next;
        row_reg      <= row_next;
        nx_reg       <= nx_next;
        tw_reg       <= tw_next;
        ox_reg       <= ox_next;
        oy_reg       <= oy_next;
        opv_reg      <= opv_next;
        oend_reg     <= oend_next;
        onx_reg      <= onx_next;
        otw_reg      <= otw_next;
    end

    assign busy               = busy_reg;
    assign pix_ch.valid       = ov_reg;
    assign pix_ch.pixel_x     = ox_reg;
    assign pix_ch.pixel_y     = oy_reg;
    assign pix_ch.pixel_valid = opv_reg;
    assign pix_ch.end_of_run  = oend_reg;
    assign pix_ch.next_x      = onx_reg;
    assign pix_ch.str_width   = otw_reg;

endmodule

`default_nettype wire

// File: sv/proportional_glyph_text_renderer_unit.sv
// Top level: cursor and width tracking, font lookup, scanner and APB register.
//
//  channel   dir  handshake      payload
//  char_ch   in   valid/ready    code, first_char, string_end, pos_x, pos_y
//  pix_ch    out  valid/ready    pixel_x, pixel_y, pixel_valid, end_of_run,
//                                next_x, str_width
//  apb       in   psel/penable   space columns at byte address 0
//
//  A character gets its font lookup and cursor update when it is accepted, then
//  one scanner step per glyph bit up to its last set bit (one step for a blank
//  glyph or a space).
//  Scanner steps stall while the result register is full and not taken.
//  Reset clears the cursor, row, width and space width (to 2); no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module proportional_glyph_text_renderer_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [pgtr_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [pgtr_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [pgtr_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    pgtr_char_if.sink                            char_ch,
    pgtr_pix_if.source                           pix_ch
);
    import pgtr_pkg::*;

    logic [SW_W-1:0]    space_cols;
    logic               busy;
    logic               accept;
    pgtr_job_t          job;

    logic [COORD_W-1:0] cursor_col_reg, cursor_col_next;
    logic [COORD_W-1:0] cursor_row_reg, cursor_row_next;
    logic [COORD_W-1:0] width_sum_reg, width_sum_next;

    logic [COORD_W-1:0] base_col;
    logic [COORD_W-1:0] base_width;
    logic               is_space;
    logic [GLYPH_W-1:0] glyph;
    logic [1:0]         ncol;
    logic [COORD_W-1:0] advance;

    pgtr_apb u_apb (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .space_cols (space_cols)
    );

    assign char_ch.ready = !busy;
    assign accept        = char_ch.valid && char_ch.ready;

    always_comb
    begin
        base_col        = char_ch.first_char ? char_ch.pos_x : cursor_col_reg;
        cursor_row_next = char_ch.first_char ? char_ch.pos_y : cursor_row_reg;
        base_width      = char_ch.first_char ? '0 : width_sum_reg;

        is_space = (char_ch.code == ASCII_SPACE);
        glyph    = is_space ? '0 : glyph_bits(char_ch.code);

        // Width judged only by whether columns two and three are blank
        if (glyph[14:10] != '0)
            ncol = 2'd3;
        else if (glyph[9:5] != '0)
            ncol = 2'd2;
        else
            ncol = 2'd1;

        if (is_space)
            advance = {{(COORD_W-SW_W){1'b0}}, space_cols} + 1'b1;
        else
            advance = {{(COORD_W-2){1'b0}}, ncol} + 1'b1;

        cursor_col_next = base_col + advance;
        width_sum_next  = base_width + advance;

        job.bits      = glyph;
        job.empty     = (glyph == '0);
        job.col       = base_col;
        job.row       = cursor_row_next;
        job.next_x    = cursor_col_next;
        job.str_width = (width_sum_next == '0) ? '0 : width_sum_next - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            width_sum_reg  <= '0;
        end
        else if (accept)
        begin
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            width_sum_reg  <= width_sum_next;
        end
    end

    pgtr_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .job    (job),
        .busy   (busy),
        .pix_ch (pix_ch)
    );

    // An accepted character always starts a scan
    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("scanner not busy after a character transaction");

    // A blank result is the only result of its character
    a_blank_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        pix_ch.valid && !pix_ch.pixel_valid |-> pix_ch.end_of_run)
        else $error("blank result without end_of_run");

    // Scanner idles only after emitting the final result of a run
    a_scan_ends_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> pix_ch.valid && pix_ch.end_of_run)
        else $error("scan finished without a final result");

    // Cursor moves only on an accepted character
    a_cursor_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(cursor_col_reg) && $stable(width_sum_reg))
        else $error("cursor changed without a character transaction");

endmodule

`default_nettype wire

// File: test/testbench.sv
// Testbench for the 3x5 glyph renderer: directed table, random strings, pixel checks.
`timescale 1ns / 1ps

module testbench;
    import pgtr_pkg::*;

    localparam logic [6:0] CH_SPACE   = 7'd32;
    localparam logic [6:0] FONT_FIRST = 7'd33;
    localparam logic [6:0] FONT_LAST  = 7'd125;

    // Font columns {col1, col2, col3}, bit 0 of a column is the top row
    localparam logic [4:0] FONT_COLS [93][3] = '{
        '{'h17, 0, 0},       '{'h03, 'h00, 'h03}, '{'h0e, 'h0e, 'h0e}, '{0, 0, 0},
        '{'h19, 'h04, 'h13}, '{0, 0, 0},          '{'h03, 0, 0},       '{'h0e, 'h11, 0},
        '{'h11, 'h0e, 0},    '{0, 0, 0},          '{'h04, 'h0e, 'h04}, '{'h10, 'h08, 0},
        '{'h04, 'h04, 0},    '{'h10, 0, 0},       '{'h18, 'h04, 'h03},
        '{'h0e, 'h11, 'h0e}, '{'h12, 'h1f, 'h10}, '{'h19, 'h15, 'h12}, '{'h11, 'h15, 'h0a},
        '{'h07, 'h04, 'h1f}, '{'h17, 'h15, 'h09}, '{'h0e, 'h15, 'h08}, '{'h01, 'h19, 'h07},
        '{'h0a, 'h15, 'h0a}, '{'h02, 'h15, 'h0e},
        '{'h0a, 0, 0},       '{'h10, 'h0a, 0},    '{'h04, 'h04, 'h0a}, '{'h0a, 'h0a, 'h0a},
        '{'h0a, 'h04, 'h04}, '{'h01, 'h15, 'h02}, '{0, 0, 0},
        '{'h1e, 'h05, 'h1e}, '{'h1f, 'h15, 'h0a}, '{'h0e, 'h11, 'h11}, '{'h1f, 'h11, 'h0e},
        '{'h1f, 'h15, 'h11}, '{'h1f, 'h05, 'h01}, '{'h0e, 'h11, 'h19}, '{'h1f, 'h04, 'h1f},
        '{'h11, 'h1f, 'h11}, '{'h11, 'h0f, 0},    '{'h1f, 'h04, 'h1b}, '{'h1f, 'h10, 'h10},
        '{'h1f, 'h02, 'h1f}, '{'h1f, 'h01, 'h1e}, '{'h1f, 'h11, 'h1f}, '{'h1f, 'h05, 'h02},
        '{'h0e, 'h11, 'h1e}, '{'h1f, 'h05, 'h1a}, '{'h12, 'h15, 'h09}, '{'h01, 'h1f, 'h01},
        '{'h1f, 'h10, 'h1f}, '{'h07, 'h18, 'h07}, '{'h1f, 'h08, 'h1f}, '{'h1b, 'h04, 'h1b},
        '{'h03, 'h14, 'h0f}, '{'h19, 'h15, 'h13},
        '{'h1f, 'h11, 0},    '{'h03, 'h04, 'h18}, '{'h11, 'h1f, 0},    '{'h02, 'h01, 'h02},
        '{'h10, 'h10, 'h10}, '{'h01, 'h02, 0},
        '{'h0c, 'h12, 'h1e}, '{'h1f, 'h12, 'h0c}, '{'h0c, 'h12, 'h12}, '{'h0c, 'h12, 'h1f},
        '{'h0c, 'h1a, 'h14}, '{'h1e, 'h05, 0},    '{'h16, 'h1e, 0},    '{'h1f, 'h02, 'h1c},
        '{'h1d, 0, 0},       '{'h10, 'h0d, 0},    '{'h1f, 'h04, 'h1a}, '{'h1f, 0, 0},
        '{'h1e, 'h04, 'h1e}, '{'h1e, 'h02, 'h1c}, '{'h0c, 'h12, 'h0c}, '{'h1e, 'h0a, 'h04},
        '{'h04, 'h0a, 'h1e}, '{'h1e, 'h04, 'h02}, '{'h16, 'h1a, 0},    '{'h0f, 'h12, 0},
        '{'h0e, 'h10, 'h1e}, '{'h06, 'h18, 'h06}, '{'h1e, 'h08, 'h1e}, '{'h12, 'h0c, 'h12},
        '{'h02, 'h14, 'h0e}, '{'h1a, 'h16, 0},
        '{'h04, 'h0e, 'h1f}, '{0, 0, 0},          '{'h1f, 'h0e, 'h04}
    };

    typedef struct packed {
        logic [6:0] code;
        logic       first_char;
        logic       string_end;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
    } char_t;

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic       lit;
        logic       last;
        logic [7:0] nx;
        logic [7:0] tw;
    } pix_t;

    typedef enum logic {ROW_CHAR, ROW_SET_SPACE} row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [6:0] code;
        logic       first_char;
        logic       string_end;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [4:0] reps;
        logic       typed;
        logic [7:0] nx;
        logic [7:0] tw;
        logic [3:0] sw;
    } dir_row_t;

    // typed rows carry the single blank result: next_x and string width
    localparam dir_row_t PLAN [19] = '{
        '{ROW_CHAR, CH_SPACE, 1'b1, 1'b0, 8'd0,   8'd0,   5'd1,  1'b1, 8'd3,   8'd2, 4'd0},
        '{ROW_CHAR, 7'd0,     1'b0, 1'b0, 8'd0,   8'd0,   5'd1,  1'b1, 8'd5,   8'd4, 4'd0},
        '{ROW_CHAR, 7'd127,   1'b0, 1'b0, 8'd0,   8'd0,   5'd1,  1'b1, 8'd7,   8'd6, 4'd0},
        '{ROW_CHAR, 7'd36,    1'b1, 1'b0, 8'd10,  8'd20,  5'd1,  1'b1, 8'd12,  8'd1, 4'd0},
        '{ROW_CHAR, 7'd124,   1'b0, 1'b1, 8'd0,   8'd0,   5'd1,  1'b1, 8'd14,  8'd3, 4'd0},
        // corner start: row wraps inside the glyph, column wraps at the next character
        '{ROW_CHAR, 7'd33,    1'b1, 1'b0, 8'd255, 8'd255, 5'd1,  1'b0, 8'd0,   8'd0, 4'd0},
        '{ROW_CHAR, 7'd125,   1'b0, 1'b0, 8'd0,   8'd0,   5'd1,  1'b0, 8'd0,   8'd0, 4'd0},
        '{ROW_CHAR, 7'd34,    1'b0, 1'b0, 8'd0,   8'd0,   5'd1,  1'b0, 8'd0,   8'd0, 4'd0},
        '{ROW_CHAR, 7'd79,    1'b1, 1'b0, 8'd100, 8'd50,  5'd1,  1'b0, 8'd0,   8'd0, 4'd0},
        '{ROW_CHAR, 7'd105,   1'b0, 1'b1, 8'd0,   8'd0,   5'd1,  1'b0, 8'd0,   8'd0, 4'd0},
        // no first_char after an end mark: same string goes on
        '{ROW_CHAR, 7'd106,   1'b0, 1'b0, 8'd0,   8'd0,   5'd1,  1'b0, 8'd0,   8'd0, 4'd0},
        '{ROW_CHAR, 7'd35,    1'b0, 1'b0, 8'd0,   8'd0,   5'd1,  1'b0, 8'd0,   8'd0, 4'd0},
        '{ROW_CHAR, 7'd64,    1'b0, 1'b1, 8'd0,   8'd0,   5'd1,  1'b0, 8'd0,   8'd0, 4'd0},
        '{ROW_SET_SPACE, 7'd0, 1'b0, 1'b0, 8'd0,  8'd0,   5'd0,  1'b0, 8'd0,   8'd0, 4'd15},
        // sixteen spaces of 16 columns: width sum wraps to zero
        '{ROW_CHAR, CH_SPACE, 1'b1, 1'b0, 8'd7,   8'd9,   5'd15, 1'b0, 8'd0,   8'd0, 4'd0},
        '{ROW_CHAR, CH_SPACE, 1'b0, 1'b1, 8'd0,   8'd0,   5'd1,  1'b1, 8'd7,   8'd0, 4'd0},
        '{ROW_SET_SPACE, 7'd0, 1'b0, 1'b0, 8'd0,  8'd0,   5'd0,  1'b0, 8'd0,   8'd0, 4'd0},
        '{ROW_CHAR, CH_SPACE, 1'b1, 1'b0, 8'd200, 8'd0,   5'd1,  1'b1, 8'd201, 8'd0, 4'd0},
        '{ROW_CHAR, 7'd77,    1'b0, 1'b1, 8'd0,   8'd0,   5'd1,  1'b0, 8'd0,   8'd0, 4'd0}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    pgtr_char_if char_ch ();
    pgtr_pix_if  pix_ch ();

    proportional_glyph_text_renderer_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .char_ch (char_ch),
        .pix_ch  (pix_ch)
    );

    // predictor state
    logic [7:0] pen_col;
    logic [7:0] pen_row;
    logic [7:0] run_width;
    logic [3:0] space_cols;

    pix_t pending_pixels[$];
    int   mismatches = 0;
    int   chars_sent = 0;
    int   pixels_seen = 0;
    int   lit_seen = 0;
    int   settings_used = 0;
    bit   no_gaps = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d pixel transactions still expected", pending_pixels.size());
        $display("*** FAILED ***");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        if (mismatches < 10)
            $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic string pix_str(input pix_t p);
        return $sformatf("(%0d,%0d) lit=%0b last=%0b next_x=%0d width=%0d",
                         p.x, p.y, p.lit, p.last, p.nx, p.tw);
    endfunction

    // Pixels one character produces, in scan order; updates cursor and width
    function automatic void render_glyph(input char_t c, ref pix_t glyph_q[$]);
        logic [4:0] cols [3];
        logic [7:0] advance;
        logic [7:0] start_col;
        logic [7:0] width_now;
        int         ncol;
        pix_t       p;
        glyph_q.delete();
        if (c.first_char)
        begin
            pen_col   = c.pos_x;
            pen_row   = c.pos_y;
            run_width = 8'd0;
        end
        start_col = pen_col;
        if (c.code == CH_SPACE)
            advance = 8'(space_cols) + 8'd1;
        else
        begin
            cols = '{5'd0, 5'd0, 5'd0};
            if (c.code >= FONT_FIRST && c.code <= FONT_LAST)
                cols = FONT_COLS[c.code - FONT_FIRST];
            ncol = (cols[2] != 0) ? 3 : (cols[1] != 0) ? 2 : 1;
            for (int i = 0; i < ncol; i++)
                for (int r = 0; r < 5; r++)
                    if (cols[i][r])
                    begin
                        p = '0;
                        p.x   = start_col + 8'(i);
                        p.y   = pen_row + 8'(r);
                        p.lit = 1'b1;
                        glyph_q.push_back(p);
                    end
            advance = 8'(ncol + 1);
        end
        pen_col   = pen_col + advance;
        run_width = run_width + advance;
        width_now = (run_width == 0) ? 8'd0 : run_width - 8'd1;
        if (glyph_q.size() == 0)
            glyph_q.push_back(pix_t'(0));
        foreach (glyph_q[k])
        begin
            glyph_q[k].nx = pen_col;
            glyph_q[k].tw = width_now;
        end
        glyph_q[glyph_q.size() - 1].last = 1'b1;
    endfunction

    task automatic send_char(input char_t c, input bit typed, input pix_t typed_pix);
        pix_t glyph_q[$];
        char_ch.valid      <= 1'b1;
        char_ch.code       <= c.code;
        char_ch.first_char <= c.first_char;
        char_ch.string_end <= c.string_end;
        char_ch.pos_x      <= c.pos_x;
        char_ch.pos_y      <= c.pos_y;
        do @(posedge clk); while (!char_ch.ready);
        render_glyph(c, glyph_q);
        if (typed)
            pending_pixels.push_back(typed_pix);
        else
            foreach (glyph_q[k])
                pending_pixels.push_back(glyph_q[k]);
        chars_sent++;
        if (!no_gaps && $urandom_range(99) < 13)
        begin
            char_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        char_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_access(input bit wr, input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {REG_SPACE_COLS, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_space_cols(input logic [3:0] value);
        logic [APB_DATA_W-1:0] readback;
        wait_drained();
        apb_access(1'b1, APB_DATA_W'(value), readback);
        @(posedge clk);
        apb_access(1'b0, '0, readback);
        if (readback !== APB_DATA_W'(value))
            note_mismatch($sformatf("space columns read %0h, wrote %0h", readback, value));
        space_cols = value;
        settings_used++;
    endtask

    // Mostly whole strings with random text; some broken framing mixed in
    task automatic run_strings(input int n_items);
        int    sent;
        int    len;
        char_t c;
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
            if (len > n_items - sent)
                len = n_items - sent;
            for (int k = 0; k < len; k++)
            begin
                case ($urandom_range(99)) inside
                    [0:14]:  c.code = CH_SPACE;
                    [15:24]: c.code = 7'($urandom_range(127));
                    default: c.code = 7'($urandom_range(FONT_FIRST, FONT_LAST));
                endcase
                c.first_char = (k == 0);
                c.string_end = (k == len - 1);
                c.pos_x = 8'($urandom);
                c.pos_y = 8'($urandom);
                if ($urandom_range(9) == 0)
                begin
                    c.first_char = 1'($urandom);
                    c.string_end = 1'($urandom);
                end
                send_char(c, 1'b0, pix_t'(0));
                sent++;
            end
        end
    endtask

    always @(posedge clk)
        pix_ch.ready <= no_gaps || ($urandom_range(99) >= 13);

    always @(posedge clk)
    begin : pixel_check
        pix_t got;
        pix_t want;
        if (rst_n && pix_ch.valid && pix_ch.ready)
        begin
            got = '{pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.pixel_valid, pix_ch.end_of_run,
                    pix_ch.next_x, pix_ch.str_width};
            pixels_seen++;
            if (got.lit)
                lit_seen++;
            if (pending_pixels.size() == 0)
                note_mismatch($sformatf("unexpected transaction %s", pix_str(got)));
            else
            begin
                want = pending_pixels.pop_front();
                if (got !== want)
                    note_mismatch($sformatf("expected %s, got %s",
                                            pix_str(want), pix_str(got)));
            end
        end
    end

    initial
    begin : main
        logic [3:0]            sw_plan [4];
        logic [APB_DATA_W-1:0] readback;
        char_t                 c;
        pix_t                  typed_pix;

        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        char_ch.valid      <= 1'b0;
        char_ch.code       <= '0;
        char_ch.first_char <= 1'b0;
        char_ch.string_end <= 1'b0;
        char_ch.pos_x      <= '0;
        char_ch.pos_y      <= '0;
        pen_col    = 8'd0;
        pen_row    = 8'd0;
        run_width  = 8'd0;
        space_cols = 4'd2;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apb_access(1'b0, '0, readback);
        if (readback !== APB_DATA_W'(space_cols))
            note_mismatch($sformatf("space columns after reset read %0h", readback));

        foreach (PLAN[i])
        begin
            if (PLAN[i].kind == ROW_SET_SPACE)
                set_space_cols(PLAN[i].sw);
            else
                for (int r = 0; r < PLAN[i].reps; r++)
                begin
                    c = '{PLAN[i].code, PLAN[i].first_char && r == 0, PLAN[i].string_end,
                          PLAN[i].pos_x, PLAN[i].pos_y};
                    typed_pix = '{8'd0, 8'd0, 1'b0, 1'b1, PLAN[i].nx, PLAN[i].tw};
                    send_char(c, PLAN[i].typed, typed_pix);
                end
        end

        sw_plan = '{4'd15, 4'($urandom_range(1, 14)), 4'd0, 4'($urandom_range(15))};
        for (int ph = 0; ph < 4; ph++)
        begin
            set_space_cols(sw_plan[ph]);
            no_gaps = (ph == 2);
            if (ph == 1)
            begin
                run_strings(8);
                // hold the sender until the block has emptied
                wait_drained();
                run_strings(9);
            end
            else
                run_strings(17);
            no_gaps = 1'b0;
        end

        wait_drained();
        repeat (32) @(posedge clk);

        $display("Rendered %0d characters into %0d pixel transactions (%0d lit)",
                 chars_sent, pixels_seen, lit_seen);
        $display("Space width written %0d times, 0 and 15 included; %0d mismatches",
                 settings_used, mismatches);
        if (pending_pixels.size() != 0)
            $display("%0d expected pixel transactions never arrived", pending_pixels.size());
        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
